/* rtl/core/mdu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared types and constants for the modular division unit.
// ----------------------------------------------------------------------------
package mdu_pkg;

    localparam int DEF_WIDTH = 32;
    localparam int FIELD_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_COP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MOD_0   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_QTSTEP,
        S_EUPD,
        S_MSTEP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/core/modular_division_unit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_division_unit_top
// Modular division dividend / divisor mod modulus by extended Euclid.
// ----------------------------------------------------------------------------
// One transaction at a time: raise i_start while o_busy is low. The result
// appears for one cycle with o_valid and cannot be stalled. The divide runs
// on a shift-subtract datapath and both multiplies share one add-mod datapath,
// each doing one bit per cycle. Each Euclid round runs one check, WIDTH
// divide steps, one remainder update and WIDTH steps of the q*t1 mod m
// multiply. After the last round a coprime pair runs a check, the final
// multiply and the result state; a pair that is not coprime runs a check and
// the result state, and a zero modulus only those two. The number of Euclid
// rounds is at most about 1.44*WIDTH+2.
module modular_division_unit_top #(
    parameter int WIDTH = mdu_pkg::DEF_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [mdu_pkg::FIELD_W-1:0]   i_dividend,
    input  wire logic [mdu_pkg::FIELD_W-1:0]   i_divisor,
    input  wire logic [mdu_pkg::FIELD_W-1:0]   i_modulus,
    output logic                               o_valid,
    output logic [mdu_pkg::FIELD_W-1:0]        o_quotient,
    output logic [mdu_pkg::FIELD_W-1:0]        o_inverse,
    output logic [mdu_pkg::FIELD_W-1:0]        o_common_divisor,
    output logic [mdu_pkg::STATUS_W-1:0]       o_status
);
    localparam int CW = $clog2(WIDTH + 1);
    localparam int FW = mdu_pkg::FIELD_W;
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    mdu_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_h, r_m, r_r0, r_r1, r_t0, r_t1, r_q, r_rem, r_acc, r_ma, r_mb;
    logic [CW-1:0]    r_cnt;
    logic             r_final;  // multiply is the final h*inv
    logic [FW-1:0]    r_quotient, r_inverse, r_gcd;
    logic [mdu_pkg::STATUS_W-1:0] r_status;

    // One shift step of the restoring divider and of the modular multiply
    logic [WIDTH:0]   div_sh;
    logic             div_ge;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH:0]   dbl, dbl_red;
    logic [WIDTH-1:0] acc2, gap, acc3;
    logic [WIDTH-1:0] op_h, op_d, op_m;
    logic [WIDTH-1:0] tdiff, tnew;

    assign op_h = WIDTH'(i_dividend);
    assign op_d = WIDTH'(i_divisor);
    assign op_m = WIDTH'(i_modulus);

    always_comb begin
        div_sh  = {r_rem, r_q[WIDTH-1]};
        div_ge  = div_sh >= {1'b0, r_r1};
        div_rem = div_ge ? WIDTH'(div_sh - {1'b0, r_r1}) : div_sh[WIDTH-1:0];
        // acc = 2*acc mod m, then add b if bit set
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        acc2    = dbl_red[WIDTH-1:0];
        gap     = r_m - r_mb;
        acc3    = r_ma[WIDTH-1] ? ((acc2 >= gap) ? acc2 - gap : acc2 + r_mb) : acc2;
        // t0 - q*t1 mod m, wrapped back into 0..m-1
        tdiff   = r_t0 - acc3;
        tnew    = (r_t0 >= acc3) ? tdiff : tdiff + r_m;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mdu_pkg::S_IDLE: begin
                if (i_start) n_state = mdu_pkg::S_QTSTEP;
            end
            mdu_pkg::S_QTSTEP: begin
                if (r_m == '0)
                    n_state = mdu_pkg::S_DONE;
                else if (r_r1 != '0)
                    n_state = mdu_pkg::S_DIV;
                else if (r_r0 != WIDTH'(1))
                    n_state = mdu_pkg::S_DONE;
                else
                    n_state = mdu_pkg::S_MSTEP;
            end
            mdu_pkg::S_DIV: begin
                if (r_cnt == LAST) n_state = mdu_pkg::S_EUPD;
            end
            mdu_pkg::S_EUPD: begin
                n_state = mdu_pkg::S_MSTEP;
            end
            mdu_pkg::S_MSTEP: begin
                if (r_cnt == LAST)
                    n_state = r_final ? mdu_pkg::S_DONE : mdu_pkg::S_QTSTEP;
            end
            mdu_pkg::S_DONE: begin
                n_state = mdu_pkg::S_IDLE;
            end
            default: n_state = mdu_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy  = (r_state != mdu_pkg::S_IDLE);
        o_valid = (r_state == mdu_pkg::S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mdu_pkg::S_IDLE;
            r_quotient <= '0;
            r_inverse  <= '0;
            r_gcd      <= '0;
            r_status   <= mdu_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            case (r_state)
                mdu_pkg::S_IDLE: begin
                    if (i_start) begin
                        r_h <= op_h; r_m <= op_m; r_r0 <= op_m; r_r1 <= op_d;
                        r_t0 <= '0;
                        r_t1 <= (op_m == WIDTH'(1)) ? '0 : WIDTH'(1);
                        r_final <= 1'b0;
                    end
                end
                // Divide r0 / r1 if r1 != 0; else finish, or h*inv if coprime
                mdu_pkg::S_QTSTEP: begin
                    if (r_m == '0) begin
                        r_gcd      <= FW'(r_r1);
                        r_status   <= mdu_pkg::ST_MOD_0;
                        r_quotient <= '0;
                        r_inverse  <= '0;
                    end else if (r_r1 != '0) begin
                        r_q <= r_r0; r_rem <= '0; r_cnt <= '0;
                    end else if (r_r0 != WIDTH'(1)) begin
                        r_gcd      <= FW'(r_r0);
                        r_status   <= mdu_pkg::ST_NOT_COP;
                        r_quotient <= '0;
                        r_inverse  <= '0;
                    end else begin
                        // Coprime: multiply h*inv next
                        r_final <= 1'b1;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_ma    <= r_h;
                        r_mb    <= r_t0;
                    end
                end
                mdu_pkg::S_DIV: begin
                    r_q   <= {r_q[WIDTH-2:0], div_ge};
                    r_rem <= div_rem;
                    r_cnt <= r_cnt + CW'(1);
                end
                // Shift remainders; set up q*t1 mod m
                mdu_pkg::S_EUPD: begin
                    r_r0 <= r_r1; r_r1 <= r_rem;
                    r_acc <= '0; r_cnt <= '0;
                    r_ma <= r_q; r_mb <= r_t1;
                end
                mdu_pkg::S_MSTEP: begin
                    r_acc <= acc3;
                    r_ma  <= {r_ma[WIDTH-2:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    // Close a multiply: post the result or advance the coefficients
                    if (r_cnt == LAST) begin
                        if (r_final) begin
                            r_quotient <= FW'(acc3);
                            r_inverse  <= FW'(r_mb);
                            r_gcd      <= FW'(r_r0);
                            r_status   <= mdu_pkg::ST_OK;
                        end else begin
                            r_t0 <= r_t1;
                            r_t1 <= tnew;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_quotient       = r_quotient;
    assign o_inverse        = r_inverse;
    assign o_common_divisor = r_gcd;
    assign o_status         = r_status;
endmodule
`default_nettype wire
